FILE: hw/rtl/rid_pkg.sv
package rid_pkg;

  // Major opcodes handled by the decoder.
  localparam logic [6:0] OPC_LUI   = 7'b0110111;
  localparam logic [6:0] OPC_JAL   = 7'b1101111;
  localparam logic [6:0] OPC_JALR  = 7'b1100111;
  localparam logic [6:0] OPC_LOAD  = 7'b0000011;
  localparam logic [6:0] OPC_STORE = 7'b0100011;
  localparam logic [6:0] OPC_OPIMM = 7'b0010011;
  localparam logic [6:0] OPC_OP    = 7'b0110011;

  // funct7 value that selects the alternate form (sub, sra, srai).
  localparam logic [6:0] F7_ALT = 7'b0100000;

  // funct3 values that need special handling.
  localparam logic [2:0] F3_ADD_SUB  = 3'd0;
  localparam logic [2:0] F3_SLL      = 3'd1;
  localparam logic [2:0] F3_SLT      = 3'd2;
  localparam logic [2:0] F3_SLTU     = 3'd3;
  localparam logic [2:0] F3_XOR      = 3'd4;
  localparam logic [2:0] F3_SHIFT_R  = 3'd5;
  localparam logic [2:0] F3_OR       = 3'd6;
  localparam logic [2:0] F3_AND      = 3'd7;
  localparam logic [2:0] F3_LOAD_BAD = 3'd7;

  // Mnemonic codes.
  localparam logic [5:0] MN_NONE = 6'd0;
  localparam logic [5:0] MN_LUI  = 6'd1;
  localparam logic [5:0] MN_JAL  = 6'd2;
  localparam logic [5:0] MN_JALR = 6'd3;
  localparam logic [5:0] MN_LB   = 6'd4;
  localparam logic [5:0] MN_SB   = 6'd11;
  localparam logic [5:0] MN_ADDI = 6'd15;
  localparam logic [5:0] MN_SLTI = 6'd16;
  localparam logic [5:0] MN_SLTIU = 6'd17;
  localparam logic [5:0] MN_XORI = 6'd18;
  localparam logic [5:0] MN_ORI  = 6'd19;
  localparam logic [5:0] MN_ANDI = 6'd20;
  localparam logic [5:0] MN_SLLI = 6'd21;
  localparam logic [5:0] MN_SRLI = 6'd22;
  localparam logic [5:0] MN_SRAI = 6'd23;
  localparam logic [5:0] MN_ADD  = 6'd24;
  localparam logic [5:0] MN_SUB  = 6'd25;
  localparam logic [5:0] MN_SLL  = 6'd26;
  localparam logic [5:0] MN_SLT  = 6'd27;
  localparam logic [5:0] MN_SLTU = 6'd28;
  localparam logic [5:0] MN_XOR  = 6'd29;
  localparam logic [5:0] MN_SRL  = 6'd30;
  localparam logic [5:0] MN_SRA  = 6'd31;
  localparam logic [5:0] MN_OR   = 6'd32;
  localparam logic [5:0] MN_AND  = 6'd33;

  // Operand layouts.
  localparam logic [2:0] LAY_NONE        = 3'd0;
  localparam logic [2:0] LAY_REG_IMM     = 3'd1;
  localparam logic [2:0] LAY_REG_REG_IMM = 3'd2;
  localparam logic [2:0] LAY_REG_OFFSET  = 3'd3;
  localparam logic [2:0] LAY_REG_REG_REG = 3'd4;

  // One decoded instruction.
  typedef struct packed {
    logic [5:0]         mnemonic;
    logic [2:0]         layout;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
  } rid_result_t;

endpackage

FILE: hw/rtl/rid_decode.sv
module rid_decode
  import rid_pkg::*;
(
  input  logic [31:0] word,
  output rid_result_t result
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_j;
  logic [31:0] imm_u;
  rid_result_t raw;

  assign opc = word[6:0];
  assign f3  = word[14:12];
  assign f7  = word[31:25];

  assign imm_i = {{20{word[31]}}, word[31:20]};
  assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
  assign imm_j = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
  assign imm_u = {word[31:12], 12'b0};

  always_comb begin
    raw = '0;
    case (opc)
      OPC_LUI: begin
        raw.mnemonic  = MN_LUI;
        raw.layout    = LAY_REG_IMM;
        raw.dest_reg  = word[11:7];
        raw.immediate = imm_u;
      end
      OPC_JAL: begin
        raw.mnemonic  = MN_JAL;
        raw.layout    = LAY_REG_IMM;
        raw.dest_reg  = word[11:7];
        raw.immediate = imm_j;
      end
      OPC_JALR: begin
        raw.mnemonic  = MN_JALR;
        raw.layout    = LAY_REG_REG_IMM;
        raw.dest_reg  = word[11:7];
        raw.src1_reg  = word[19:15];
        raw.immediate = imm_i;
      end
      OPC_LOAD: begin
        raw.mnemonic  = (f3 == F3_LOAD_BAD) ? MN_NONE : (MN_LB + {3'b0, f3});
        raw.layout    = LAY_REG_OFFSET;
        raw.dest_reg  = word[11:7];
        raw.src1_reg  = word[19:15];
        raw.immediate = imm_i;
      end
      OPC_STORE: begin
        raw.mnemonic  = f3[2] ? MN_NONE : (MN_SB + {4'b0, f3[1:0]});
        raw.layout    = LAY_REG_OFFSET;
        raw.src1_reg  = word[19:15];
        raw.src2_reg  = word[24:20];
        raw.immediate = imm_s;
      end
      OPC_OPIMM: begin
        raw.layout    = LAY_REG_REG_IMM;
        raw.dest_reg  = word[11:7];
        raw.src1_reg  = word[19:15];
        raw.immediate = imm_i;
        case (f3)
          F3_ADD_SUB: raw.mnemonic = MN_ADDI;
          F3_SLL:     raw.mnemonic = MN_SLLI;
          F3_SLT:     raw.mnemonic = MN_SLTI;
          F3_SLTU:    raw.mnemonic = MN_SLTIU;
          F3_XOR:     raw.mnemonic = MN_XORI;
          F3_SHIFT_R: begin
            if (f7 == F7_ALT) begin
              raw.mnemonic  = MN_SRAI;
              raw.immediate = {27'b0, word[24:20]};
            end else begin
              raw.mnemonic = MN_SRLI;
            end
          end
          F3_OR:      raw.mnemonic = MN_ORI;
          default:    raw.mnemonic = MN_ANDI;
        endcase
      end
      OPC_OP: begin
        raw.layout   = LAY_REG_REG_REG;
        raw.dest_reg = word[11:7];
        raw.src1_reg = word[19:15];
        raw.src2_reg = word[24:20];
        case (f3)
          F3_ADD_SUB: raw.mnemonic = (f7 == F7_ALT) ? MN_SUB : MN_ADD;
          F3_SLL:     raw.mnemonic = MN_SLL;
          F3_SLT:     raw.mnemonic = MN_SLT;
          F3_SLTU:    raw.mnemonic = MN_SLTU;
          F3_XOR:     raw.mnemonic = MN_XOR;
          F3_SHIFT_R: raw.mnemonic = (f7 == F7_ALT) ? MN_SRA : MN_SRL;
          F3_OR:      raw.mnemonic = MN_OR;
          default:    raw.mnemonic = MN_AND;
        endcase
      end
      default: begin
        raw = '0;
      end
    endcase
  end

  // An invalid encoding reports nothing but zeros.
  assign result = (raw.mnemonic == MN_NONE) ? '0 : raw;

endmodule

FILE: hw/rtl/riscv_instruction_decoder_top.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------------
// request  | start (in), busy (out) | instr_word
// result   | done (out)             | mnemonic, layout, dest_reg, src1_reg,
//          |                        | src2_reg, immediate
//
// A request is taken at any rising edge with start high; busy is held low, so a
// new request may arrive in every cycle and the block sustains one per cycle.
// The edge that takes a request loads the input register, and the decoded result
// register loads from it after that; done is high for one cycle while the result
// register holds that request's result. The synchronous reset clears both valid
// flags only. The receiver cannot stall, so nothing holds the pipeline back.
module riscv_instruction_decoder_top
  import rid_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        instr_word,
  output logic               done,
  output logic [5:0]         mnemonic,
  output logic [2:0]         layout,
  output logic [4:0]         dest_reg,
  output logic [4:0]         src1_reg,
  output logic [4:0]         src2_reg,
  output logic signed [31:0] immediate
);

  logic        in_valid;
  logic [31:0] in_word;
  rid_result_t decoded;
  rid_result_t result;

  // The decoder never needs to refuse a request.
  assign busy = 1'b0;

  // Input register: captures the instruction word of each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_word <= instr_word;
    end
  end

  // Purely combinational decode between the two registers.
  rid_decode u_decode (
    .word   (in_word),
    .result (decoded)
  );

  // Result register: the strobe is the registered copy of the input valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      result <= decoded;
    end
  end

  assign mnemonic  = result.mnemonic;
  assign layout    = result.layout;
  assign dest_reg  = result.dest_reg;
  assign src1_reg  = result.src1_reg;
  assign src2_reg  = result.src2_reg;
  assign immediate = result.immediate;

endmodule
